// ===== src/mmed_pkg.sv =====
`timescale 1ns / 1ps

package mmed_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SET_LEN = 32760;
    localparam int CFG_BITS    = 23;
    localparam int LEN_BITS    = $clog2(MAX_SET_LEN + 1);
    localparam int SUM_BITS    = CFG_BITS + 1;

    localparam logic [CFG_BITS-1:0] K_MIN = CFG_BITS'(1) << FRAC_BITS;
    localparam logic [CFG_BITS-1:0] K_MAX = CFG_BITS'(MAX_SET_LEN) << FRAC_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic
    {
        KIND_SAMPLE,
        KIND_FLUSH
    } kind_t;

    typedef struct packed
    {
        kind_t                   kind;
        logic [SAMPLE_BITS-1:0]  sample;
    } item_t;

endpackage

// ===== src/mmed_if.sv =====
`timescale 1ns / 1ps

interface mmed_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface mmed_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] min_value;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] max_value;
    logic                                  padded;

    modport source (output valid, output min_value, output max_value, output padded,
                    input ready);
    modport sink   (input valid, input min_value, input max_value, input padded,
                    output ready);
endinterface

// ===== src/mmed_front.sv =====
`timescale 1ns / 1ps

module mmed_front
(
    input  logic              clk,
    input  logic              rst_n,
    mmed_in_if.sink           samples,
    output logic              push_valid,
    input  logic              push_ready,
    output mmed_pkg::item_t   push_item
);

    logic            valid_reg;
    logic            valid_next;
    mmed_pkg::item_t item_reg;
    mmed_pkg::item_t item_next;
    logic            accept;

    assign samples.ready = !valid_reg || push_ready;
    assign accept        = samples.valid && samples.ready;
    assign push_valid    = valid_reg;
    assign push_item     = item_reg;

    always_comb
    begin
        item_next  = item_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            item_next.kind   = (samples.operation == mmed_pkg::OP_FLUSH)
                               ? mmed_pkg::KIND_FLUSH : mmed_pkg::KIND_SAMPLE;
            item_next.sample = samples.sample;
            valid_next       = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== src/mmed_queue.sv =====
`timescale 1ns / 1ps

module mmed_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mmed_pkg::item_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mmed_pkg::item_t   pop_item
);

    mmed_pkg::item_t                   store [mmed_pkg::QUEUE_DEPTH];
    logic [mmed_pkg::PTR_BITS-1:0]     wr_ptr_reg;
    logic [mmed_pkg::PTR_BITS-1:0]     wr_ptr_next;
    logic [mmed_pkg::PTR_BITS-1:0]     rd_ptr_reg;
    logic [mmed_pkg::PTR_BITS-1:0]     rd_ptr_next;
    logic [mmed_pkg::CNT_BITS-1:0]     count_reg;
    logic [mmed_pkg::CNT_BITS-1:0]     count_next;
    logic                              push;
    logic                              pop;

    assign push_ready = (count_reg != mmed_pkg::CNT_BITS'(mmed_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mmed_back.sv =====
`timescale 1ns / 1ps

module mmed_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mmed_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  mmed_pkg::item_t                    pop_item,
    mmed_out_if.source                         envelope
);

    localparam int SB = mmed_pkg::SAMPLE_BITS;

    logic [mmed_pkg::CFG_BITS-1:0]   k_cfg_reg;
    logic [mmed_pkg::CFG_BITS-1:0]   k_clamped;
    logic [mmed_pkg::SUM_BITS-1:0]   sum;

    logic signed [SB-1:0]            run_min_reg;
    logic signed [SB-1:0]            run_min_next;
    logic signed [SB-1:0]            run_max_reg;
    logic signed [SB-1:0]            run_max_next;
    logic [mmed_pkg::LEN_BITS-1:0]   left_reg;
    logic [mmed_pkg::LEN_BITS-1:0]   left_next;
    logic [mmed_pkg::FRAC_BITS-1:0]  residue_reg;
    logic [mmed_pkg::FRAC_BITS-1:0]  residue_next;
    logic                            open_reg;
    logic                            open_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [SB-1:0]            out_min_reg;
    logic signed [SB-1:0]            out_min_next;
    logic signed [SB-1:0]            out_max_reg;
    logic signed [SB-1:0]            out_max_next;
    logic                            out_pad_reg;
    logic                            out_pad_next;

    logic signed [SB-1:0]            s;
    logic                            pop;
    logic                            emit;

    assign pop_ready          = !out_valid_reg || envelope.ready;
    assign pop                = pop_valid && pop_ready;
    assign s                  = signed'(pop_item.sample);
    assign envelope.valid     = out_valid_reg;
    assign envelope.min_value = out_min_reg;
    assign envelope.max_value = out_max_reg;
    assign envelope.padded    = out_pad_reg;

    always_comb
    begin
        priority if (k_cfg_reg < mmed_pkg::K_MIN)
        begin
            k_clamped = mmed_pkg::K_MIN;
        end
        else if (k_cfg_reg > mmed_pkg::K_MAX)
        begin
            k_clamped = mmed_pkg::K_MAX;
        end
        else
        begin
            k_clamped = k_cfg_reg;
        end
        sum = mmed_pkg::SUM_BITS'(residue_reg) + mmed_pkg::SUM_BITS'(k_clamped);
    end

    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        left_next    = left_reg;
        residue_next = residue_reg;
        open_next    = open_reg;
        emit         = 1'b0;
        out_min_next = out_min_reg;
        out_max_next = out_max_reg;
        out_pad_next = out_pad_reg;

        if (pop)
        begin
            unique case (pop_item.kind)
                mmed_pkg::KIND_FLUSH:
                begin
                    emit         = open_reg;
                    out_min_next = (run_min_reg < 0) ? run_min_reg : '0;
                    out_max_next = (run_max_reg > 0) ? run_max_reg : '0;
                    out_pad_next = 1'b1;
                    run_min_next = '0;
                    run_max_next = '0;
                    left_next    = '0;
                    residue_next = '0;
                    open_next    = 1'b0;
                end
                mmed_pkg::KIND_SAMPLE:
                begin
                    if (!open_reg)
                    begin
                        residue_next = sum[mmed_pkg::FRAC_BITS-1:0];
                        left_next    = sum[mmed_pkg::FRAC_BITS +: mmed_pkg::LEN_BITS] - 1'b1;
                        run_min_next = s;
                        run_max_next = s;
                    end
                    else
                    begin
                        run_min_next = (s < run_min_reg) ? s : run_min_reg;
                        run_max_next = (s > run_max_reg) ? s : run_max_reg;
                        left_next    = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                    end
                    emit         = (left_next == '0);
                    open_next    = !emit;
                    out_min_next = run_min_next;
                    out_max_next = run_max_next;
                    out_pad_next = 1'b0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (envelope.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg     <= mmed_pkg::K_MIN;
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            left_reg      <= '0;
            residue_reg   <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                k_cfg_reg <= cfg_data;
            end
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            left_reg      <= left_next;
            residue_reg   <= residue_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_min_reg <= out_min_next;
            out_max_reg <= out_max_next;
            out_pad_reg <= out_pad_next;
        end
    end

    a_open_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> left_reg != '0)
        else $error("open set with no samples left");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_min_reg <= out_max_reg)
        else $error("envelope minimum above maximum");

    a_pad_spans_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_pad_reg |-> out_min_reg <= 0 && out_max_reg >= 0)
        else $error("padded beat does not include zero");

    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_item.kind == mmed_pkg::KIND_FLUSH |=> !open_reg && residue_reg == '0)
        else $error("flush left a set or phase behind");

endmodule

// ===== src/minmax_envelope_decimator_top.sv =====
`timescale 1ns / 1ps

// Min/max envelope decimator. Takes one sample or flush beat per cycle while
// samples.ready is high and returns one min/max beat per completed set of
// floor((i+1)k)-floor(ik) samples, k taken from cfg_data (8 fraction bits,
// clamped 1.0..32760). A flush closes an open set as if zero-padded, marks
// it padded and restarts the phase. Sustained rate is one beat per cycle
// while the output is not stalled, set by the back-end set update. Beats pass
// the front register and two-entry queue, results the output register. Write
// cfg_data only when idle; it applies from the next set opened.
module minmax_envelope_decimator_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mmed_pkg::CFG_BITS-1:0]  cfg_data,
    mmed_in_if.sink                        samples,
    mmed_out_if.source                     envelope
);

    logic            push_valid;
    logic            push_ready;
    mmed_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    mmed_pkg::item_t pop_item;

    mmed_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mmed_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mmed_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .envelope   (envelope)
    );

endmodule

// ===== tb/sv/minmax_envelope_decimator_top_test.sv =====
`timescale 1ns / 1ps

module minmax_envelope_decimator_top_test;

    import mmed_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRESSURE_CYCLES = 300;

    typedef struct
    {
        logic                           op;
        logic signed [SAMPLE_BITS-1:0]  s;
    } beat_t;

    typedef struct
    {
        logic signed [SAMPLE_BITS-1:0]  min_value;
        logic signed [SAMPLE_BITS-1:0]  max_value;
        logic                           padded;
    } envelope_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_BITS-1:0]    cfg_data;

    mmed_in_if  samples ();
    mmed_out_if envelope ();

    minmax_envelope_decimator_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples),
        .envelope (envelope)
    );

    beat_t      to_send[$];
    envelope_t  pending_envelopes[$];

    // envelope model state
    logic [CFG_BITS-1:0]            k_reg = K_MIN;
    logic signed [SAMPLE_BITS-1:0]  run_min = '0;
    logic signed [SAMPLE_BITS-1:0]  run_max = '0;
    logic [15:0]                    left = '0;
    logic [FRAC_BITS-1:0]           residue = '0;
    bit                             set_open = 1'b0;

    bit     tx_taken = 1'b0;
    bit     rx_taken = 1'b0;
    bit     offering = 1'b0;
    bit     hold_off = 1'b0;
    bit     pressure_go = 1'b0;
    int     tx_gap = 0;
    int     rx_gap = 0;
    int     tx_run = 0;
    int     rx_run = 0;
    bit     tx_quiet = 1'b0;
    bit     rx_quiet = 1'b0;

    int     failures = 0;
    int     beats_sent = 0;
    int     flushes_sent = 0;
    int     envelopes_seen = 0;
    int     padded_seen = 0;
    int     settings_used = 0;
    int     cycle_count = 0;

    logic [CFG_BITS-1:0] k_settings[13];

    always #1 clk = ~clk;

    function automatic int pick_wait(inout int run_len, inout bit no_idle);
        if (run_len == 0)
        begin
            run_len = $urandom_range(10, 60);
            no_idle = ($urandom_range(0, 2) == 0);
        end
        run_len--;
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic predict_beat(input logic op, input logic signed [SAMPLE_BITS-1:0] s);
        logic [CFG_BITS-1:0]                k;
        logic [SUM_BITS-1:0]                sum;
        logic [SUM_BITS-FRAC_BITS-1:0]      len;
        envelope_t                          e;
        if (op == OP_FLUSH)
        begin
            if (set_open)
            begin
                e.min_value = (run_min < 0) ? run_min : '0;
                e.max_value = (run_max > 0) ? run_max : '0;
                e.padded = 1'b1;
                pending_envelopes.push_back(e);
            end
            run_min = '0;
            run_max = '0;
            left = '0;
            residue = '0;
            set_open = 1'b0;
            return;
        end
        if (!set_open)
        begin
            k = (k_reg < K_MIN) ? K_MIN : ((k_reg > K_MAX) ? K_MAX : k_reg);
            sum = residue + k;
            len = sum[SUM_BITS-1:FRAC_BITS];
            residue = sum[FRAC_BITS-1:0];
            left = 16'(len - 1'b1);
            run_min = s;
            run_max = s;
            set_open = 1'b1;
        end
        else
        begin
            if (s < run_min)
                run_min = s;
            if (s > run_max)
                run_max = s;
            if (left > 0)
                left--;
        end
        if (left == 0)
        begin
            e.min_value = run_min;
            e.max_value = run_max;
            e.padded = 1'b0;
            pending_envelopes.push_back(e);
            set_open = 1'b0;
        end
    endtask

    task automatic queue_beat(input logic op, input logic signed [SAMPLE_BITS-1:0] s);
        beat_t b;
        b.op = op;
        b.s = s;
        to_send.push_back(b);
    endtask

    task automatic queue_random(input int count, input int flush_odds);
        beat_t b;
        for (int i = 0; i < count; i++)
        begin
            b.op = ($urandom_range(1, flush_odds) == 1) ? OP_FLUSH : OP_SAMPLE;
            case ($urandom_range(0, 7))
                0: b.s = 16'h7fff;
                1: b.s = 16'h8000;
                2: b.s = 16'($urandom_range(0, 8)) - 16'd4;
                default: b.s = 16'($urandom());
            endcase
            to_send.push_back(b);
        end
    endtask

    task automatic drain();
        while (to_send.size() != 0 || samples.valid || pending_envelopes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_k(input logic [CFG_BITS-1:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_data = v;
        k_reg = v;
        settings_used++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tx_taken)
            begin
                tx_taken = 1'b0;
                offering = 1'b0;
                tx_gap = pick_wait(tx_run, tx_quiet);
            end
            if (!offering)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (to_send.size() > 0)
                begin
                    samples.operation <= to_send[0].op;
                    samples.sample <= to_send[0].s;
                    void'(to_send.pop_front());
                    offering = 1'b1;
                end
            end
            samples.valid <= offering;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_taken)
            begin
                rx_taken = 1'b0;
                rx_gap = pick_wait(rx_run, rx_quiet);
            end
            else if (rx_gap > 0)
                rx_gap--;
            envelope.ready <= (rx_gap == 0) && !hold_off;
        end
    end

    // long receiver hold-off so the input side backs up
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        envelope_t e;
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
            begin
                predict_beat(samples.operation, samples.sample);
                tx_taken = 1'b1;
                beats_sent++;
                if (samples.operation == OP_FLUSH)
                    flushes_sent++;
            end
            if (envelope.valid && envelope.ready)
            begin
                rx_taken = 1'b1;
                envelopes_seen++;
                if (envelope.padded)
                    padded_seen++;
                if (pending_envelopes.size() == 0)
                begin
                    $display("%0t: unexpected envelope beat min %0d max %0d padded %0b",
                             $time, envelope.min_value, envelope.max_value, envelope.padded);
                    failures++;
                end
                else
                begin
                    e = pending_envelopes.pop_front();
                    if (envelope.min_value !== e.min_value)
                    begin
                        $display("%0t: min_value expected %0d actual %0d",
                                 $time, e.min_value, envelope.min_value);
                        failures++;
                    end
                    if (envelope.max_value !== e.max_value)
                    begin
                        $display("%0t: max_value expected %0d actual %0d",
                                 $time, e.max_value, envelope.max_value);
                        failures++;
                    end
                    if (envelope.padded !== e.padded)
                    begin
                        $display("%0t: padded expected %0b actual %0b",
                                 $time, e.padded, envelope.padded);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.operation = OP_SAMPLE;
        samples.sample = '0;
        envelope.ready = 1'b0;

        k_settings = '{CFG_BITS'(0), CFG_BITS'(1), CFG_BITS'(255), CFG_BITS'(256),
                       CFG_BITS'(257), CFG_BITS'('h1c0), CFG_BITS'('h2a5),
                       CFG_BITS'('h4cd), CFG_BITS'('h1000), CFG_BITS'(0), K_MAX,
                       K_MAX + 1'b1, {CFG_BITS{1'b1}}};
        k_settings[9] = CFG_BITS'($urandom_range(256, 'h3000));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset length of one sample per set
        queue_beat(OP_FLUSH, 16'sd0);
        queue_beat(OP_SAMPLE, 16'h7fff);
        queue_beat(OP_SAMPLE, 16'h8000);
        queue_beat(OP_SAMPLE, 16'sd0);
        queue_beat(OP_SAMPLE, -16'sd1);

        // 3.5 samples per set: 3, then 4, then padded partials
        set_k(CFG_BITS'('h380));
        queue_beat(OP_SAMPLE, 16'h7fff);
        queue_beat(OP_SAMPLE, 16'h8000);
        queue_beat(OP_SAMPLE, 16'sd5);
        queue_beat(OP_SAMPLE, 16'sd100);
        queue_beat(OP_SAMPLE, 16'sd200);
        queue_beat(OP_FLUSH, 16'sd0);
        queue_beat(OP_SAMPLE, -16'sd7);
        queue_beat(OP_SAMPLE, -16'sd3);
        queue_beat(OP_FLUSH, 16'h7fff);
        queue_beat(OP_FLUSH, 16'sd0);
        queue_beat(OP_SAMPLE, 16'h7fff);
        queue_beat(OP_FLUSH, 16'sd0);
        queue_beat(OP_SAMPLE, 16'h8000);
        queue_beat(OP_FLUSH, 16'hffff);

        set_k(K_MIN);
        pressure_go = 1'b1;
        queue_random(150, 40);

        foreach (k_settings[i])
        begin
            set_k(k_settings[i]);
            if (k_settings[i] >= (CFG_BITS'(64) << FRAC_BITS))
                queue_random(60, 12);
            else
                queue_random(110, 40);
        end

        drain();
        $display("Sent %0d beats (%0d flushes) over %0d length settings.",
                 beats_sent, flushes_sent, settings_used);
        $display("Checked %0d envelope beats, %0d of them padded.", envelopes_seen, padded_seen);
        if (failures == 0 && pending_envelopes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
